FILE: rtl/core/two_sided_cusum_shift_detector_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-sided CUSUM shift detector
// Shared helpers so that every assertion reports in one consistent way.
// ----------------------------------------------------------------------------
`ifndef TWO_SIDED_CUSUM_SHIFT_DETECTOR_TOP_MACROS_SVH
`define TWO_SIDED_CUSUM_SHIFT_DETECTOR_TOP_MACROS_SVH

// A clocked property that is switched off while the given reset is low.
`define CUSUM_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// The same on the usual clk and arst_n names of the scope.
`define CUSUM_ASSERT(lbl, prop, msg) \
	`CUSUM_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

FILE: rtl/core/cusum_pkg.sv
// ----------------------------------------------------------------------------
// CUSUM package
// Codes, constants, types and helpers shared by the shift detector files.
// ----------------------------------------------------------------------------
package cusum_pkg;

	// Fixed widths of the work items and the configuration port.
	localparam int ALLOW_W     = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int SHIFT_W     = 2;

	// Default parameter values.
	localparam int DEF_SAMPLE_WIDTH = 16;
	localparam int DEF_SUM_WIDTH    = 24;
	localparam int DEF_COUNT_WIDTH  = 32;

	// Threshold after reset: 5.0 in Q16.8.
	localparam int THRESHOLD_RESET = 1280;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_MEAN      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ALLOWANCE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd2;

	// Operation codes of an input beat.
	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	// Shift codes of a result beat.
	localparam logic [SHIFT_W-1:0] SHIFT_NONE = 2'd0;
	localparam logic [SHIFT_W-1:0] SHIFT_UP   = 2'd1;
	localparam logic [SHIFT_W-1:0] SHIFT_DOWN = 2'd2;

	// Control of the input stage as seen by the update stage.
	typedef struct packed {
		logic valid;
		logic clear;
	} cusum_s1_ctl_t;

	function automatic int cusum_max(int a, int b);
		return (a > b) ? a : b;
	endfunction

endpackage

FILE: rtl/core/cusum_in_if.sv
// ----------------------------------------------------------------------------
// CUSUM input channel
// Valid/ready channel that carries one operation and one sample per beat.
// ----------------------------------------------------------------------------
interface cusum_in_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic                           operation;
	logic signed [SAMPLE_WIDTH-1:0] sample;

	modport source (output valid, output operation, output sample, input ready);
	modport sink   (input valid, input operation, input sample, output ready);
endinterface

FILE: rtl/core/cusum_out_if.sv
// ----------------------------------------------------------------------------
// CUSUM result channel
// Valid/ready channel that carries one detector result per beat.
// ----------------------------------------------------------------------------
interface cusum_out_if #(
	parameter int SUM_WIDTH   = 24,
	parameter int COUNT_WIDTH = 32
);
	logic                   valid;
	logic                   ready;
	logic [1:0]             shift;
	logic [SUM_WIDTH-1:0]   fired_sum;
	logic [SUM_WIDTH-1:0]   upper_total;
	logic [SUM_WIDTH-1:0]   lower_total;
	logic [COUNT_WIDTH-1:0] upshifts;
	logic [COUNT_WIDTH-1:0] downshifts;
	logic [COUNT_WIDTH-1:0] samples_seen;

	modport source (
		output valid, output shift, output fired_sum, output upper_total,
		output lower_total, output upshifts, output downshifts,
		output samples_seen, input ready
	);
	modport sink (
		input valid, input shift, input fired_sum, input upper_total,
		input lower_total, input upshifts, input downshifts,
		input samples_seen, output ready
	);
endinterface

FILE: rtl/core/cusum_cfg_if.sv
// ----------------------------------------------------------------------------
// CUSUM configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface cusum_cfg_if #(
	parameter int DATA_W = 24
);
	logic              valid;
	logic              ready;
	logic [1:0]        index;
	logic [DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/cusum_cfg_regs.sv
// ----------------------------------------------------------------------------
// CUSUM configuration registers
// Holds the reference mean, the allowance and the threshold.
// ----------------------------------------------------------------------------
module cusum_cfg_regs
	import cusum_pkg::*;
#(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
	parameter int SUM_WIDTH    = DEF_SUM_WIDTH,
	parameter int DATA_W       = DEF_SUM_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	cusum_cfg_if.sink               cfg,
	output logic [SAMPLE_WIDTH-1:0] ref_mean,
	output logic [ALLOW_W-1:0]      allowance,
	output logic [SUM_WIDTH-1:0]    threshold
);

	logic [SAMPLE_WIDTH-1:0] mean_q;
	logic [ALLOW_W-1:0]      allow_q;
	logic [SUM_WIDTH-1:0]    thresh_q;

	// Writes are registered directly, so the port never pushes back.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q   <= '0;
			allow_q  <= '0;
			thresh_q <= SUM_WIDTH'(THRESHOLD_RESET);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MEAN:      mean_q   <= cfg.data[SAMPLE_WIDTH-1:0];
				REG_ALLOWANCE: allow_q  <= cfg.data[ALLOW_W-1:0];
				REG_THRESHOLD: thresh_q <= cfg.data[SUM_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign ref_mean  = mean_q;
	assign allowance = allow_q;
	assign threshold = thresh_q;

endmodule

FILE: rtl/core/cusum_in_stage.sv
// ----------------------------------------------------------------------------
// CUSUM input stage
// Registers an accepted beat together with its two signed sum increments.
// ----------------------------------------------------------------------------
module cusum_in_stage
	import cusum_pkg::*;
#(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
	parameter int STEP_W       = DEF_SAMPLE_WIDTH + 2
) (
	input  logic                     clk,
	input  logic                     arst_n,
	cusum_in_if.sink                 samples,
	input  logic [SAMPLE_WIDTH-1:0]  ref_mean,
	input  logic [ALLOW_W-1:0]       allowance,
	input  logic                     advance,
	output cusum_s1_ctl_t            ctl,
	output logic signed [STEP_W-1:0] up_step,
	output logic signed [STEP_W-1:0] dn_step
);

	logic                     valid_s1;
	logic                     clear_s1;
	logic signed [STEP_W-1:0] up_step_s1;
	logic signed [STEP_W-1:0] dn_step_s1;
	logic signed [STEP_W-1:0] samp_x;
	logic signed [STEP_W-1:0] mean_x;
	logic signed [STEP_W-1:0] allow_x;
	logic                     take;

	// The stage frees itself in the same cycle that the update stage takes it.
	assign samples.ready = !valid_s1 || advance;
	assign take          = samples.valid && samples.ready;

	// The user must keep configuration stable while items are in flight (the
	// block does not enforce it), so the increments can be formed as the beat enters.
	assign samp_x  = {{(STEP_W - SAMPLE_WIDTH){samples.sample[SAMPLE_WIDTH-1]}},
		samples.sample};
	assign mean_x  = {{(STEP_W - SAMPLE_WIDTH){ref_mean[SAMPLE_WIDTH-1]}},
		ref_mean};
	assign allow_x = {{(STEP_W - ALLOW_W){1'b0}}, allowance};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			clear_s1   <= (samples.operation == OP_CLEAR);
			up_step_s1 <= samp_x - mean_x - allow_x;
			dn_step_s1 <= mean_x - samp_x - allow_x;
		end
	end

	assign ctl.valid = valid_s1;
	assign ctl.clear = clear_s1;
	assign up_step   = up_step_s1;
	assign dn_step   = dn_step_s1;

endmodule

FILE: rtl/core/cusum_update.sv
// ----------------------------------------------------------------------------
// CUSUM update stage
// Updates both sums and the counters and loads the result register.
// ----------------------------------------------------------------------------
module cusum_update
	import cusum_pkg::*;
#(
	parameter int SUM_WIDTH   = DEF_SUM_WIDTH,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
	parameter int STEP_W      = DEF_SAMPLE_WIDTH + 2
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cusum_s1_ctl_t            ctl,
	input  logic signed [STEP_W-1:0] up_step,
	input  logic signed [STEP_W-1:0] dn_step,
	input  logic [SUM_WIDTH-1:0]     threshold,
	output logic                     advance,
	cusum_out_if.source              results
);

	localparam int EXT_W = cusum_max(SUM_WIDTH + 1, STEP_W) + 1;

	logic [SUM_WIDTH-1:0]    upper_q;
	logic [SUM_WIDTH-1:0]    lower_q;
	logic [COUNT_WIDTH-1:0]  up_cnt_q;
	logic [COUNT_WIDTH-1:0]  dn_cnt_q;
	logic [COUNT_WIDTH-1:0]  smp_cnt_q;

	logic                    res_valid_q;
	logic [SHIFT_W-1:0]      res_shift_q;
	logic [SUM_WIDTH-1:0]    res_fired_q;
	logic [SUM_WIDTH-1:0]    res_upper_q;
	logic [SUM_WIDTH-1:0]    res_lower_q;
	logic [COUNT_WIDTH-1:0]  res_up_q;
	logic [COUNT_WIDTH-1:0]  res_dn_q;
	logic [COUNT_WIDTH-1:0]  res_smp_q;

	logic signed [EXT_W-1:0] up_raw;
	logic signed [EXT_W-1:0] dn_raw;
	logic [SUM_WIDTH-1:0]    up_cl;
	logic [SUM_WIDTH-1:0]    dn_cl;
	logic                    up_fire;
	logic                    dn_fire;
	logic [SUM_WIDTH-1:0]    upper_nx;
	logic [SUM_WIDTH-1:0]    lower_nx;
	logic [SUM_WIDTH-1:0]    fired_nx;
	logic [SHIFT_W-1:0]      shift_nx;
	logic [COUNT_WIDTH-1:0]  up_cnt_nx;
	logic [COUNT_WIDTH-1:0]  dn_cnt_nx;
	logic [COUNT_WIDTH-1:0]  smp_cnt_nx;

	assign advance = ctl.valid && (!res_valid_q || results.ready);

	always_comb begin
		up_raw = $signed({{(EXT_W - SUM_WIDTH){1'b0}}, upper_q})
			+ $signed({{(EXT_W - STEP_W){up_step[STEP_W-1]}}, up_step});
		dn_raw = $signed({{(EXT_W - SUM_WIDTH){1'b0}}, lower_q})
			+ $signed({{(EXT_W - STEP_W){dn_step[STEP_W-1]}}, dn_step});

		// Clamp at zero below and at all ones above.
		if (up_raw[EXT_W-1]) begin
			up_cl = '0;
		end else if (|up_raw[EXT_W-2:SUM_WIDTH]) begin
			up_cl = '1;
		end else begin
			up_cl = up_raw[SUM_WIDTH-1:0];
		end
		if (dn_raw[EXT_W-1]) begin
			dn_cl = '0;
		end else if (|dn_raw[EXT_W-2:SUM_WIDTH]) begin
			dn_cl = '1;
		end else begin
			dn_cl = dn_raw[SUM_WIDTH-1:0];
		end

		// The upper sum has priority; the lower one fires only otherwise.
		up_fire = (up_cl > threshold);
		dn_fire = !up_fire && (dn_cl > threshold);

		upper_nx   = up_fire ? '0 : up_cl;
		lower_nx   = dn_fire ? '0 : dn_cl;
		fired_nx   = up_fire ? up_cl : (dn_fire ? dn_cl : '0);
		shift_nx   = up_fire ? SHIFT_UP : (dn_fire ? SHIFT_DOWN : SHIFT_NONE);
		up_cnt_nx  = up_cnt_q + COUNT_WIDTH'(up_fire);
		dn_cnt_nx  = dn_cnt_q + COUNT_WIDTH'(dn_fire);
		smp_cnt_nx = smp_cnt_q + COUNT_WIDTH'(1);

		if (ctl.clear) begin
			upper_nx   = '0;
			lower_nx   = '0;
			fired_nx   = '0;
			shift_nx   = SHIFT_NONE;
			up_cnt_nx  = '0;
			dn_cnt_nx  = '0;
			smp_cnt_nx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q   <= '0;
			lower_q   <= '0;
			up_cnt_q  <= '0;
			dn_cnt_q  <= '0;
			smp_cnt_q <= '0;
		end else if (advance) begin
			upper_q   <= upper_nx;
			lower_q   <= lower_nx;
			up_cnt_q  <= up_cnt_nx;
			dn_cnt_q  <= dn_cnt_nx;
			smp_cnt_q <= smp_cnt_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_shift_q <= shift_nx;
			res_fired_q <= fired_nx;
			res_upper_q <= upper_nx;
			res_lower_q <= lower_nx;
			res_up_q    <= up_cnt_nx;
			res_dn_q    <= dn_cnt_nx;
			res_smp_q   <= smp_cnt_nx;
		end
	end

	assign results.valid        = res_valid_q;
	assign results.shift        = res_shift_q;
	assign results.fired_sum    = res_fired_q;
	assign results.upper_total  = res_upper_q;
	assign results.lower_total  = res_lower_q;
	assign results.upshifts     = res_up_q;
	assign results.downshifts   = res_dn_q;
	assign results.samples_seen = res_smp_q;

endmodule

FILE: rtl/core/two_sided_cusum_shift_detector_top.sv
// ----------------------------------------------------------------------------
// Two-sided CUSUM shift detector, top level
// Path: each input beat passes the input stage register, then the result register.
// One item/cycle while results are taken; a stalled result beat holds the flow.
// Reset (arst_n low) zeroes sums, counters, valid flags, mean and allowance; threshold is 1280.
// ----------------------------------------------------------------------------
//
// Structure
//   The input stage registers each accepted beat and, using the configured
//   reference mean and allowance, forms the signed increments of the upper
//   and the lower sum. The update stage adds them to the stored sums, clamps
//   each at zero and at the top of its range, compares against the
//   threshold and loads the result register. The upper sum is checked first;
//   only when it does not fire can the lower sum fire. A firing sum restarts
//   at zero and its pre-restart value is reported as fired_sum.
//
// Flow control
//   The input stage is freed in the same cycle its beat moves into the
//   result register, so a new sample beat is taken every cycle as long as
//   results are taken. While a result beat waits, one more input beat is
//   still taken and parked in the input stage.
//
// Configuration
//   Register writes are registered directly and are expected only while the
//   block is idle. Writes to an index beyond the threshold are dropped.
//
module two_sided_cusum_shift_detector_top
	import cusum_pkg::*;
#(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
	parameter int SUM_WIDTH    = DEF_SUM_WIDTH,
	parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
) (
	input logic         clk,
	input logic         arst_n,
	cusum_cfg_if.sink   cfg,
	cusum_in_if.sink    samples,
	cusum_out_if.source results
);

	// Increment width covers the sample minus the mean minus the allowance.
	localparam int STEP_W = cusum_max(SAMPLE_WIDTH + 1, ALLOW_W + 1) + 1;
	localparam int CFG_DATA_W = cusum_max(cusum_max(SAMPLE_WIDTH, ALLOW_W), SUM_WIDTH);

	logic [SAMPLE_WIDTH-1:0] ref_mean;
	logic [ALLOW_W-1:0]      allowance;
	logic [SUM_WIDTH-1:0]    threshold;
	logic                    advance;
	cusum_s1_ctl_t           ctl;
	logic signed [STEP_W-1:0] up_step;
	logic signed [STEP_W-1:0] dn_step;

	// Configuration register file.
	cusum_cfg_regs #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.SUM_WIDTH    (SUM_WIDTH),
		.DATA_W       (CFG_DATA_W)
	) u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.ref_mean  (ref_mean),
		.allowance (allowance),
		.threshold (threshold)
	);

	// Input register: beat plus precomputed sum increments.
	cusum_in_stage #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.STEP_W       (STEP_W)
	) u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.ref_mean  (ref_mean),
		.allowance (allowance),
		.advance   (advance),
		.ctl       (ctl),
		.up_step   (up_step),
		.dn_step   (dn_step)
	);

	// State update and result register.
	cusum_update #(
		.SUM_WIDTH   (SUM_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH),
		.STEP_W      (STEP_W)
	) u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.up_step   (up_step),
		.dn_step   (dn_step),
		.threshold (threshold),
		.advance   (advance),
		.results   (results)
	);

endmodule

FILE: rtl/core/cusum_checker.sv
// ----------------------------------------------------------------------------
// CUSUM port checker
// Watches the result channel of the shift detector at its ports.
// ----------------------------------------------------------------------------
`include "two_sided_cusum_shift_detector_top_macros.svh"

module cusum_checker
	import cusum_pkg::*;
#(
	parameter int SUM_WIDTH   = DEF_SUM_WIDTH,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   res_valid,
	input logic                   res_ready,
	input logic [SHIFT_W-1:0]     res_shift,
	input logic [SUM_WIDTH-1:0]   res_fired,
	input logic [SUM_WIDTH-1:0]   res_upper,
	input logic [SUM_WIDTH-1:0]   res_lower,
	input logic [COUNT_WIDTH-1:0] res_samples
);

	// A stalled result beat keeps its payload.
	`CUSUM_ASSERT(a_res_hold, (res_valid && !res_ready) |=> (res_valid && $stable(res_shift) && $stable(res_fired) && $stable(res_samples)), "result beat changed while stalled")

	// Without a shift nothing fired.
	`CUSUM_ASSERT(a_quiet_zero, (res_valid && res_shift == SHIFT_NONE) |-> (res_fired == '0), "fired_sum nonzero without a shift")

	// An upshift restarts the upper sum.
	`CUSUM_ASSERT(a_up_restart, (res_valid && res_shift == SHIFT_UP) |-> (res_upper == '0 && res_fired != '0), "upper sum not restarted on upshift")

	// A downshift restarts the lower sum.
	`CUSUM_ASSERT(a_dn_restart, (res_valid && res_shift == SHIFT_DOWN) |-> (res_lower == '0 && res_fired != '0), "lower sum not restarted on downshift")

endmodule

bind two_sided_cusum_shift_detector_top cusum_checker #(
	.SUM_WIDTH   (SUM_WIDTH),
	.COUNT_WIDTH (COUNT_WIDTH)
) u_cusum_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (results.valid),
	.res_ready   (results.ready),
	.res_shift   (results.shift),
	.res_fired   (results.fired_sum),
	.res_upper   (results.upper_total),
	.res_lower   (results.lower_total),
	.res_samples (results.samples_seen)
);
